[rtl/hps_pkg.sv]
// Shared constants and types for the heading PID steering block.
// Used by heading_pid_steering and its port checker; no dependencies.
`timescale 1ns / 1ps

package hps_pkg;

    // Field widths
    localparam int HDG_W     = 12;
    localparam int ERR_W     = 12;
    localparam int CHG_W     = 13;
    localparam int TOTAL_W   = 32;
    localparam int PWM_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = HDG_W + ERR_W + CHG_W + TOTAL_W + PWM_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Default fractional bits of the Q8.8 gains
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // One full and one half turn in tenths of a degree
    localparam int FULL_TURN = 3600;
    localparam int HALF_TURN = 1800;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL     = 3'd5;

    // Register reset values
    localparam logic signed [HDG_W-1:0] DECLINATION_RST = 12'sd85;
    localparam logic [HDG_W-1:0]        TARGET_RST      = 12'd2700;
    localparam logic [GAIN_W-1:0]       GAIN_PROP_RST   = 16'd256;
    localparam logic [GAIN_W-1:0]       GAIN_RATE_RST   = 16'd0;
    localparam logic [GAIN_W-1:0]       GAIN_INT_RST    = 16'd0;
    localparam logic [PWM_W-1:0]        NEUTRAL_RST     = 16'd1500;

    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [CHG_W-1:0]   chg_t;
    typedef logic signed [TOTAL_W-1:0] total_t;

endpackage

[rtl/heading_pid_steering.sv]
// PID steering controller on compass heading: top level.
// Depends on hps_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

// Usage
//   s_axis: one magnetic heading per transfer, tdata[11:0] in tenths of a degree.
//   m_axis: one result per input item: corrected heading, wrapped error, error
//           change, saturated error sum and steering pulse width.
//   cfg:    register writes (index, data), always ready; write only while idle.
// Timing
//   Four register stages: input, error/sum, products, result; one item per
//   cycle is sustained while m_axis_tready stays high. The product stage
//   (three multipliers) sets the stage count.
// Reset
//   rst_n clears all stage valids, the previous error and the error sum, and
//   loads the register defaults.
// Back-pressure
//   Each stage moves on when the next is empty or moving, so bubbles collapse;
//   with the result register held by m_axis_tready low, upstream stages keep
//   filling until all four are full, then s_axis_tready drops.
module heading_pid_steering #(
    parameter int GAIN_FRAC_BITS = hps_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // [11:0] heading_tenths, [15:12] zero
    input  logic [hps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [11:0] true_heading, [23:12] heading_error, [36:24] error_change,
    // [68:37] error_total, [84:69] steering_pwm, [87:85] zero
    output logic [hps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hps_pkg::*;

    localparam int SUM_W  = TOTAL_W + 1;
    localparam int PP_W   = GAIN_W + 1 + ERR_W;
    localparam int PR_W   = GAIN_W + 1 + CHG_W;
    localparam int PI_W   = GAIN_W + 1 + TOTAL_W;
    localparam int ACC_W  = PI_W + 2;
    localparam int PWMX_W = ACC_W + 1;
    localparam int WIDE_W = HDG_W + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sh8000_0000);
    localparam logic signed [PWMX_W-1:0] PWM_TOP = PWMX_W'((64'd1 << PWM_W) - 1);

    // Configuration registers
    logic signed [HDG_W-1:0] decl_reg;
    logic [HDG_W-1:0]        target_reg;
    logic [GAIN_W-1:0]       gain_prop_reg;
    logic [GAIN_W-1:0]       gain_rate_reg;
    logic [GAIN_W-1:0]       gain_int_reg;
    logic [PWM_W-1:0]        neutral_reg;

    // Controller state
    err_t   last_error_reg;
    total_t error_acc_reg;

    // Stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy_o;

    // Stage 1: input register
    logic [HDG_W-1:0] hdg_reg;

    // Stage 2: heading, error and sum
    logic signed [WIDE_W-1:0] th_raw, th_wrap, err_raw, err_wrap;
    logic [HDG_W-1:0]         th_next, th2_reg;
    err_t                     err_next, err2_reg;
    chg_t                     chg_next, chg2_reg;
    logic signed [SUM_W-1:0]  sum_raw;
    total_t                   sum_next, sum2_reg;

    // Stage 3: products
    logic signed [PP_W-1:0] pp_next, pp_reg;
    logic signed [PR_W-1:0] pr_next, pr_reg;
    logic signed [PI_W-1:0] pi_next, pi_reg;
    logic [HDG_W-1:0]       th3_reg;
    err_t                   err3_reg;
    chg_t                   chg3_reg;
    total_t                 sum3_reg;

    // Result stage
    logic signed [ACC_W-1:0]  acc_sum, acc_shift;
    logic signed [PWMX_W-1:0] pwm_wide;
    logic [PWM_W-1:0]         pwm_next;
    logic [OUT_FIELD_W-1:0]   out_next, out_reg;

    assign rdy_o = !vo_reg || m_axis_tready;
    assign rdy3  = !v3_reg || rdy_o;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg      <= DECLINATION_RST;
            target_reg    <= TARGET_RST;
            gain_prop_reg <= GAIN_PROP_RST;
            gain_rate_reg <= GAIN_RATE_RST;
            gain_int_reg  <= GAIN_INT_RST;
            neutral_reg   <= NEUTRAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DECLINATION: decl_reg      <= cfg_data[HDG_W-1:0];
                CFG_TARGET:      target_reg    <= cfg_data[HDG_W-1:0];
                CFG_GAIN_PROP:   gain_prop_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_RATE:   gain_rate_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_INT:    gain_int_reg  <= cfg_data[GAIN_W-1:0];
                CFG_NEUTRAL:     neutral_reg   <= cfg_data[PWM_W-1:0];
                default:         ;
            endcase
        end
    end

    // Heading correction and error wrap: one step by a full turn covers
    // every input pattern.
    always_comb
    begin
        th_raw = WIDE_W'($signed({2'b00, hdg_reg})) + WIDE_W'(decl_reg);
        if (th_raw < 0)
            th_wrap = th_raw + WIDE_W'(FULL_TURN);
        else if (th_raw >= WIDE_W'(FULL_TURN))
            th_wrap = th_raw - WIDE_W'(FULL_TURN);
        else
            th_wrap = th_raw;
        th_next = th_wrap[HDG_W-1:0];

        err_raw = $signed({2'b00, target_reg}) - $signed({2'b00, th_next});
        if (err_raw > WIDE_W'(HALF_TURN))
            err_wrap = err_raw - WIDE_W'(FULL_TURN);
        else if (err_raw < -WIDE_W'(HALF_TURN))
            err_wrap = err_raw + WIDE_W'(FULL_TURN);
        else
            err_wrap = err_raw;
        err_next = err_wrap[ERR_W-1:0];

        chg_next = CHG_W'(err_next) - CHG_W'(last_error_reg);

        sum_raw = SUM_W'(error_acc_reg) + SUM_W'(err_next);
        if (sum_raw > SUM_MAX)
            sum_next = SUM_MAX[TOTAL_W-1:0];
        else if (sum_raw < SUM_MIN)
            sum_next = SUM_MIN[TOTAL_W-1:0];
        else
            sum_next = sum_raw[TOTAL_W-1:0];
    end

    assign pp_next = $signed({1'b0, gain_prop_reg}) * err2_reg;
    assign pr_next = $signed({1'b0, gain_rate_reg}) * chg2_reg;
    assign pi_next = $signed({1'b0, gain_int_reg}) * sum2_reg;

    // Floor shift of the product sum, then neutral minus output, clamped
    always_comb
    begin
        acc_sum   = ACC_W'(pp_reg) + ACC_W'(pr_reg) + ACC_W'(pi_reg);
        acc_shift = acc_sum >>> GAIN_FRAC_BITS;
        pwm_wide  = $signed({{(PWMX_W-PWM_W){1'b0}}, neutral_reg}) - PWMX_W'(acc_shift);
        if (pwm_wide < 0)
            pwm_next = '0;
        else if (pwm_wide > PWM_TOP)
            pwm_next = '1;
        else
            pwm_next = pwm_wide[PWM_W-1:0];
        out_next = {pwm_next, sum3_reg, chg3_reg, err3_reg, th3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            last_error_reg <= '0;
            error_acc_reg  <= '0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_axis_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_o)
                vo_reg <= v3_reg;
            // state moves once per item, as it leaves the input register
            if (v1_reg && rdy2)
            begin
                last_error_reg <= err_next;
                error_acc_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && rdy1)
            hdg_reg <= s_axis_tdata[HDG_W-1:0];
        if (v1_reg && rdy2)
        begin
            th2_reg  <= th_next;
            err2_reg <= err_next;
            chg2_reg <= chg_next;
            sum2_reg <= sum_next;
        end
        if (v2_reg && rdy3)
        begin
            pp_reg   <= pp_next;
            pr_reg   <= pr_next;
            pi_reg   <= pi_next;
            th3_reg  <= th2_reg;
            err3_reg <= err2_reg;
            chg3_reg <= chg2_reg;
            sum3_reg <= sum2_reg;
        end
        if (v3_reg && rdy_o)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_reg};

endmodule

[rtl/hps_checker.sv]
// Port-level checks for heading_pid_steering, attached by bind.
// Depends on hps_pkg for payload widths.
`timescale 1ns / 1ps

module hps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic [hps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);
    import hps_pkg::*;

    logic [HDG_W-1:0] th_field;
    err_t             err_field;

    assign th_field  = m_axis_tdata[HDG_W-1:0];
    assign err_field = m_axis_tdata[HDG_W+ERR_W-1:HDG_W];

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with the result register empty no stage can block the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> th_field < HDG_W'(FULL_TURN))
        else $error("corrected heading out of range");

    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (err_field <= ERR_W'(HALF_TURN)) && (err_field >= -ERR_W'(HALF_TURN)))
        else $error("heading error out of range");

endmodule

bind heading_pid_steering hps_checker u_hps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
